@@ src/pllf2rw_pkg.sv @@
// Shared widths, constants and types for the PLL frequency to register word block.
`default_nettype none
package pllf2rw_pkg;

  // Field and internal widths
  localparam int FREQ_W   = 16;
  localparam int WORD_W   = 32;
  localparam int MHZ_W    = 13;
  localparam int K_W      = 3;
  localparam int SCALED_W = 22;
  localparam int INT_W    = 14;
  localparam int REM_W    = 8;
  localparam int FRAC_W   = 10;
  localparam int MOD_W    = 10;

  // Frequency limits in tenths of a MHz
  localparam logic [FREQ_W-1:0] FREQ_MIN_TENTHS = 16'd350;
  localparam logic [FREQ_W-1:0] FREQ_MAX_TENTHS = 16'd44000;

  // VCO window in MHz, compared against the shifted integer MHz value
  localparam logic [SCALED_W-1:0] VCO_MIN_MHZ = 22'd2200;
  localparam logic [SCALED_W-1:0] VCO_MAX_MHZ = 22'd4400;
  localparam logic [K_W-1:0]      MAX_DIV_LOG2 = 3'd6;

  // Divide by ten as a multiply by a reciprocal, exact for all 16-bit values
  localparam logic [16:0] RECIP10       = 17'd52429;
  localparam int          RECIP10_SHIFT = 19;

  // Divide by five for 10-bit values, exact below 1024
  localparam logic [7:0] RECIP5       = 8'd205;
  localparam int         RECIP5_SHIFT = 10;

  // Divide by 250 as a multiply by a reciprocal, exact for every SCALED_W-bit dividend
  localparam int                    RECIP250_W     = 23;
  localparam logic [RECIP250_W-1:0] RECIP250       = 23'd4294968;
  localparam int                    RECIP250_SHIFT = 30;

  // Phase-detector frequency in tenths of a MHz
  localparam logic [REM_W:0] PFD_TENTHS = 9'd250;
  localparam logic [MOD_W-1:0] MOD_START = 10'd1000;

  localparam logic [WORD_W-1:0] R1_BASE     = 32'h0000_8001;
  localparam logic [WORD_W-1:0] R4_BASE     = 32'h008C_803C;
  localparam logic [WORD_W-1:0] RF_OFF_WORD = 32'h00EC_801C;

  // Divider start, busy and completion, travelling between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ src/pllf2rw_div.sv @@
// Divider by the phase-detector constant: reciprocal multiply, then remainder, one step a cycle.
`default_nettype none
module pllf2rw_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pllf2rw_pkg::div_ctrl_t            ctrl,
  input  wire logic [pllf2rw_pkg::SCALED_W-1:0]  dividend,
  output pllf2rw_pkg::div_stat_t                 stat,
  output logic [pllf2rw_pkg::INT_W-1:0]          quotient,
  output logic [pllf2rw_pkg::REM_W-1:0]          remainder
);

  localparam int PROD_W = pllf2rw_pkg::SCALED_W + pllf2rw_pkg::RECIP250_W;

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic                             step_r, step_nxt;
  logic [pllf2rw_pkg::SCALED_W-1:0] num_r, num_nxt;
  logic [pllf2rw_pkg::INT_W-1:0]    quo_r, quo_nxt;
  logic [pllf2rw_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [PROD_W-1:0]                prod;
  logic [pllf2rw_pkg::SCALED_W-1:0] back;
  logic [pllf2rw_pkg::REM_W-1:0]    rem_low;

  // The quotient is taken in the first step and multiplied back in the second.
  assign prod    = num_r * pllf2rw_pkg::RECIP250;
  assign back    = pllf2rw_pkg::SCALED_W'(quo_r) *
                   pllf2rw_pkg::SCALED_W'(pllf2rw_pkg::PFD_TENTHS);
  assign rem_low = pllf2rw_pkg::REM_W'(num_r - back);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      step_nxt = 1'b0;
      num_nxt  = dividend;
    end else if (busy_r) begin
      if (!step_r) begin
        quo_nxt  = prod[pllf2rw_pkg::RECIP250_SHIFT +: pllf2rw_pkg::INT_W];
        step_nxt = 1'b1;
      end else begin
        rem_nxt  = rem_low;
        step_nxt = 1'b0;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

@@ src/pll_frequency_to_register_words.sv @@
// Top level: turns a requested frequency into four synthesizer register words.
//
//  Channel | Direction | tdata (low bit up)          | tuser | tlast
//  in_     | slave     | freq_tenths_mhz [15:0]      | -     | -
//  out_    | master    | reg_word [31:0]             | -     | last_word
//
// A request is accepted and clamped, divided by ten, then takes one to seven divider search
// steps, the reciprocal divide by 250 and one to four steps for each reduction pass, and is
// then sent as four words. The search and the reduction passes set how long a request takes.
// in_tready is high only while idle.
// Reset is synchronous and active low and clears the sequencer and output valid.
// A stalled output holds its word; the sequencer waits until the register is taken.
`default_nettype none
module pll_frequency_to_register_words (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] freq_tenths_mhz
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] reg_word
  output logic             out_tlast   // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MHZ,
    ST_SEARCH,
    ST_DIV,
    ST_RED5,
    ST_RED2,
    ST_EMIT
  } state_t;

  state_t                              state_r, state_nxt;
  logic [pllf2rw_pkg::FREQ_W-1:0]      t_r, t_nxt;
  logic [pllf2rw_pkg::MHZ_W-1:0]       mhz_r, mhz_nxt;
  logic [pllf2rw_pkg::K_W-1:0]         k_r, k_nxt;
  logic [pllf2rw_pkg::INT_W-1:0]       int_r, int_nxt;
  logic [pllf2rw_pkg::FRAC_W-1:0]      frac_r, frac_nxt;
  logic [pllf2rw_pkg::MOD_W-1:0]       mod_r, mod_nxt;
  logic [1:0]                          idx_r, idx_nxt;
  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [pllf2rw_pkg::WORD_W-1:0]      out_tdata_r, out_tdata_nxt;
  logic                                out_tlast_r, out_tlast_nxt;

  logic [pllf2rw_pkg::FREQ_W-1:0]      t_clamped;
  logic [32:0]                         mhz_prod;
  logic [pllf2rw_pkg::SCALED_W-1:0]    vco_val;
  logic [pllf2rw_pkg::SCALED_W-1:0]    scaled;
  logic                                in_window;
  logic [17:0]                         frac_prod, mod_prod;
  logic [pllf2rw_pkg::FRAC_W-1:0]      frac_q5, mod_q5;
  logic                                frac_div5, mod_div5;
  logic                                out_free;

  pllf2rw_pkg::div_ctrl_t              div_ctrl;
  pllf2rw_pkg::div_stat_t              div_stat;
  logic [pllf2rw_pkg::INT_W-1:0]       div_quo;
  logic [pllf2rw_pkg::REM_W-1:0]       div_rem;

  pllf2rw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .dividend  (scaled),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    if (in_tdata < pllf2rw_pkg::FREQ_MIN_TENTHS) begin
      t_clamped = pllf2rw_pkg::FREQ_MIN_TENTHS;
    end else if (in_tdata > pllf2rw_pkg::FREQ_MAX_TENTHS) begin
      t_clamped = pllf2rw_pkg::FREQ_MAX_TENTHS;
    end else begin
      t_clamped = in_tdata;
    end
  end

  assign mhz_prod  = t_r * pllf2rw_pkg::RECIP10;
  assign vco_val   = pllf2rw_pkg::SCALED_W'(mhz_r) << k_r;
  assign in_window = (vco_val >= pllf2rw_pkg::VCO_MIN_MHZ) &&
                     (vco_val <= pllf2rw_pkg::VCO_MAX_MHZ);
  assign scaled    = pllf2rw_pkg::SCALED_W'(t_r) << k_r;

  // Divisibility by five: quotient by reciprocal, then check that it multiplies back.
  assign frac_prod = frac_r * pllf2rw_pkg::RECIP5;
  assign mod_prod  = mod_r * pllf2rw_pkg::RECIP5;
  assign frac_q5   = pllf2rw_pkg::FRAC_W'(frac_prod >> pllf2rw_pkg::RECIP5_SHIFT);
  assign mod_q5    = pllf2rw_pkg::MOD_W'(mod_prod >> pllf2rw_pkg::RECIP5_SHIFT);
  assign frac_div5 = (pllf2rw_pkg::FRAC_W'({frac_q5, 2'b00} + frac_q5) == frac_r);
  assign mod_div5  = (pllf2rw_pkg::MOD_W'({mod_q5, 2'b00} + mod_q5) == mod_r);

  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    mhz_nxt        = mhz_r;
    k_nxt          = k_r;
    int_nxt        = int_r;
    frac_nxt       = frac_r;
    mod_nxt        = mod_r;
    idx_nxt        = idx_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    div_ctrl.start = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          t_nxt     = t_clamped;
          state_nxt = ST_MHZ;
        end
      end
      ST_MHZ: begin
        mhz_nxt   = pllf2rw_pkg::MHZ_W'(mhz_prod >> pllf2rw_pkg::RECIP10_SHIFT);
        k_nxt     = '0;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        // The largest divider is taken without a window check.
        if (in_window || (k_r == pllf2rw_pkg::MAX_DIV_LOG2)) begin
          div_ctrl.start = 1'b1;
          state_nxt      = ST_DIV;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          int_nxt   = div_quo;
          frac_nxt  = {div_rem, 2'b00};
          mod_nxt   = pllf2rw_pkg::MOD_START;
          state_nxt = ST_RED5;
        end
      end
      ST_RED5: begin
        if (frac_div5 && mod_div5) begin
          frac_nxt = frac_q5;
          mod_nxt  = mod_q5;
        end else begin
          state_nxt = ST_RED2;
        end
      end
      ST_RED2: begin
        if (!frac_r[0] && !mod_r[0] && (mod_r > pllf2rw_pkg::MOD_W'(1))) begin
          frac_nxt = frac_r >> 1;
          mod_nxt  = mod_r >> 1;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tlast_nxt  = (idx_r == 2'd3);
          unique case (idx_r)
            2'd0: out_tdata_nxt = pllf2rw_pkg::RF_OFF_WORD;
            2'd1: out_tdata_nxt = (pllf2rw_pkg::WORD_W'(int_r) << 15) +
                                  (pllf2rw_pkg::WORD_W'(frac_r) << 3);
            2'd2: out_tdata_nxt = pllf2rw_pkg::R1_BASE +
                                  (pllf2rw_pkg::WORD_W'(mod_r) << 3);
            2'd3: out_tdata_nxt = pllf2rw_pkg::R4_BASE +
                                  (pllf2rw_pkg::WORD_W'(k_r) << 20);
            default: out_tdata_nxt = pllf2rw_pkg::RF_OFF_WORD;
          endcase
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 2'd3) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      idx_r        <= idx_nxt;
    end
    t_r         <= t_nxt;
    mhz_r       <= mhz_nxt;
    k_r         <= k_nxt;
    int_r       <= int_nxt;
    frac_r      <= frac_nxt;
    mod_r       <= mod_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for the PLL frequency to register word block.
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int MAX_WAIT        = 12;

  typedef struct {
    logic [pllf2rw_pkg::WORD_W-1:0] word;
    logic                           last;
  } reg_word_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [pllf2rw_pkg::FREQ_W-1:0] in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [pllf2rw_pkg::WORD_W-1:0] out_tdata;
  logic                           out_tlast;

  reg_word_t pending_words[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  bit        sender_idles = 1'b1;
  bit        receiver_idles = 1'b1;

  pll_frequency_to_register_words dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out the four register words for one requested frequency.
  function automatic void predict_register_words(
    input logic [pllf2rw_pkg::FREQ_W-1:0] request
  );
    int unsigned tenths, mhz, div_log2, scaled, int_part, frac, modulus;
    reg_word_t   w;
    begin
      tenths = 32'(request);
      if (tenths < pllf2rw_pkg::FREQ_MIN_TENTHS) tenths = pllf2rw_pkg::FREQ_MIN_TENTHS;
      if (tenths > pllf2rw_pkg::FREQ_MAX_TENTHS) tenths = pllf2rw_pkg::FREQ_MAX_TENTHS;
      mhz = tenths / 10;
      div_log2 = 0;
      while (div_log2 < pllf2rw_pkg::MAX_DIV_LOG2 &&
             !((mhz << div_log2) >= pllf2rw_pkg::VCO_MIN_MHZ &&
               (mhz << div_log2) <= pllf2rw_pkg::VCO_MAX_MHZ))
        div_log2++;
      scaled   = tenths << div_log2;
      int_part = scaled / pllf2rw_pkg::PFD_TENTHS;
      frac     = (scaled * 4) % pllf2rw_pkg::MOD_START;
      modulus  = pllf2rw_pkg::MOD_START;
      while (frac % 5 == 0 && modulus % 5 == 0) begin
        frac    = frac / 5;
        modulus = modulus / 5;
      end
      while (frac % 2 == 0 && modulus % 2 == 0 && modulus > 1) begin
        frac    = frac / 2;
        modulus = modulus / 2;
      end
      w.last = 1'b0;
      w.word = pllf2rw_pkg::RF_OFF_WORD;
      pending_words.push_back(w);
      w.word = (int_part << 15) + (frac << 3);
      pending_words.push_back(w);
      w.word = pllf2rw_pkg::R1_BASE + (modulus << 3);
      pending_words.push_back(w);
      w.word = pllf2rw_pkg::R4_BASE + (div_log2 << 20);
      w.last = 1'b1;
      pending_words.push_back(w);
    end
  endfunction

  // Valid is left high after a request so that a following one with no gap keeps it up.
  task automatic send_frequency(input logic [pllf2rw_pkg::FREQ_W-1:0] request);
    int gap;
    begin
      gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= request;
      do @(posedge clk); while (!in_tready);
      predict_register_words(request);
    end
  endtask

  task automatic wait_for_results;
    begin
      in_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  function automatic logic [pllf2rw_pkg::FREQ_W-1:0] random_frequency;
    int unsigned pick;
    begin
      pick = $urandom_range(0, 19);
      if (pick < 2)
        random_frequency = pllf2rw_pkg::FREQ_W'(
          $urandom_range(0, pllf2rw_pkg::FREQ_MIN_TENTHS - 1));
      else if (pick < 4)
        random_frequency = pllf2rw_pkg::FREQ_W'(
          $urandom_range(pllf2rw_pkg::FREQ_MAX_TENTHS + 1, 65535));
      else if (pick < 5)
        random_frequency = pllf2rw_pkg::FREQ_W'($urandom);
      else
        random_frequency = pllf2rw_pkg::FREQ_W'(
          $urandom_range(pllf2rw_pkg::FREQ_MIN_TENTHS, pllf2rw_pkg::FREQ_MAX_TENTHS));
    end
  endfunction

  task automatic test_clamping;
    begin
      send_frequency(16'd0);
      send_frequency(16'd1);
      send_frequency(16'd349);
      send_frequency(16'd350);
      send_frequency(16'd351);
      send_frequency(16'd44000);
      send_frequency(16'd44001);
      send_frequency(16'hFFFF);
      send_frequency(16'hAAAA);
      send_frequency(16'h5555);
      wait_for_results();
    end
  endtask

  // Each frequency sits just either side of a change in the output divider.
  task automatic test_divider_boundaries;
    begin
      send_frequency(16'd21999);
      send_frequency(16'd22000);
      send_frequency(16'd10999);
      send_frequency(16'd11000);
      send_frequency(16'd5499);
      send_frequency(16'd5500);
      send_frequency(16'd689);
      send_frequency(16'd690);
      wait_for_results();
    end
  endtask

  task automatic test_fraction_reduction;
    begin
      send_frequency(16'd25000);
      send_frequency(16'd22001);
      send_frequency(16'd22005);
      send_frequency(16'd30123);
      send_frequency(16'd35010);
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back;
    begin
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      repeat (30) send_frequency(random_frequency());
      wait_for_results();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
    end
  endtask

  task automatic test_random_requests;
    begin
      repeat (67) begin
        send_frequency(random_frequency());
        // Now and then the source holds off until every word has been returned.
        if ($urandom_range(0, 15) == 0) wait_for_results();
      end
      wait_for_results();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clamping();
    test_divider_boundaries();
    test_fraction_reduction();
    test_back_to_back();
    test_random_requests();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Sink side: while receiver_idles is set, stalls for a random number of cycles before each word.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = receiver_idles ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    reg_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_tdata !== want.word) begin
          $display("%0t: reg_word mismatch, expected %h, actual %h",
                   $time, want.word, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last_word mismatch, expected %b, actual %b",
                   $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
